// ===== rtl/noise_floor_calibrate_and_listen_assert.svh =====
// Assertion macros for the noise-floor calibration and listen block.
`ifndef NOISE_FLOOR_CALIBRATE_AND_LISTEN_ASSERT_SVH
`define NOISE_FLOOR_CALIBRATE_AND_LISTEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NFCAL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define NFCAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NFCAL_ASSERT_NOW(label, ante, cons, msg)
`define NFCAL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/nfcal_pkg.sv =====
// Shared types, codes and width helpers for the noise-floor block.
package nfcal_pkg;

   localparam int RSSI_W     = 9;
   localparam int CHAN_W     = 3;
   localparam int LEVEL_W    = 10;
   localparam int THRESH_W   = LEVEL_W + 1;
   localparam int SQUELCH_W  = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_CAL    = 1'b0;
   localparam logic CMD_LISTEN = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_SQUELCH = 2'd0;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] chan;
      logic              save;
   } nfcal_tag_type;

   // At least one calibration sample always survives the trim.
   function automatic int eff_drop(input int cal, input int drop);
      return (drop < cal) ? drop : cal - 1;
   endfunction

   function automatic int sum_width(input int cal, input int listen);
      int most;
      most = (cal > listen) ? cal : listen;
      return $clog2(most * (2 ** (RSSI_W - 1)) + 1) + 1;
   endfunction

endpackage

// ===== rtl/nfcal_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module nfcal_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read-first: a read and a write to one entry in the same cycle return the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nfcal_burst.sv =====
// Burst tracker: running sum, sample count and the largest calibration samples.
module nfcal_burst #(
   parameter int CAL_SAMPLES    = 16,
   parameter int DROP_HIGHEST   = 4,
   parameter int LISTEN_SAMPLES = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  logic                                    cmd,
   input  logic [nfcal_pkg::CHAN_W-1:0]            chan_index,
   input  logic signed [nfcal_pkg::RSSI_W-1:0]     rssi_dbm,
   input  logic                                    save_floor,
   output logic                                    done,
   output nfcal_pkg::nfcal_tag_type                done_tag,
   output logic signed
      [nfcal_pkg::sum_width(CAL_SAMPLES, LISTEN_SAMPLES)-1:0] done_sum
);
   import nfcal_pkg::*;

   localparam int EFF_DROP    = eff_drop(CAL_SAMPLES, DROP_HIGHEST);
   localparam int KEEP_N      = (EFF_DROP > 0) ? EFF_DROP : 1;
   localparam int KIDX_W      = (KEEP_N > 1) ? $clog2(KEEP_N) : 1;
   localparam int MAX_SAMPLES = (CAL_SAMPLES > LISTEN_SAMPLES) ? CAL_SAMPLES : LISTEN_SAMPLES;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = sum_width(CAL_SAMPLES, LISTEN_SAMPLES);

   logic [CNT_W-1:0]         count_ff, count_in, seen, target;
   logic signed [SUM_W-1:0]  sum_ff, sum_in, sum_base;
   logic signed [SUM_W-1:0]  kept_sum_ff, kept_sum_in, kept_base;
   logic                     burst_cmd_ff;
   logic [CHAN_W-1:0]        burst_chan_ff;
   logic signed [RSSI_W-1:0] kept_ff [KEEP_N];
   logic signed [RSSI_W-1:0] kept_in [KEEP_N];
   logic signed [RSSI_W-1:0] min_val;
   logic [KIDX_W-1:0]        min_idx;
   logic                     restart, fill, replace;

   // A sample with another command or channel throws away the burst in progress.
   assign restart   = (count_ff == '0) || (cmd != burst_cmd_ff) || (chan_index != burst_chan_ff);
   assign seen      = restart ? '0 : count_ff;
   assign sum_base  = restart ? '0 : sum_ff;
   assign kept_base = restart ? '0 : kept_sum_ff;
   assign sum_in    = sum_base + SUM_W'(rssi_dbm);
   assign count_in  = seen + CNT_W'(1);
   assign target    = (cmd == CMD_LISTEN) ? CNT_W'(LISTEN_SAMPLES) : CNT_W'(CAL_SAMPLES);

   // Lowest-index smallest kept sample is the one that gets replaced.
   always_comb begin
      min_val = kept_ff[0];
      min_idx = '0;
      for (int i = 1; i < KEEP_N; i++) begin
         if (kept_ff[i] < min_val) begin
            min_val = kept_ff[i];
            min_idx = KIDX_W'(i);
         end
      end
   end

   assign fill    = int'(seen) < EFF_DROP;
   assign replace = !fill && (rssi_dbm > min_val);

   always_comb begin
      kept_in     = kept_ff;
      kept_sum_in = kept_base;
      if ((cmd == CMD_CAL) && (EFF_DROP > 0)) begin
         for (int i = 0; i < KEEP_N; i++) begin
            if ((fill && (int'(seen) == i)) || (replace && (int'(min_idx) == i))) begin
               kept_in[i] = rssi_dbm;
            end
         end
         if (fill) begin
            kept_sum_in = kept_base + SUM_W'(rssi_dbm);
         end else if (replace) begin
            kept_sum_in = kept_base + SUM_W'(rssi_dbm) - SUM_W'(min_val);
         end
      end
   end

   assign done     = accept && (count_in >= target);
   assign done_tag = '{kind: cmd, chan: chan_index, save: save_floor};
   assign done_sum = (cmd == CMD_CAL) ? (sum_in - kept_sum_in) : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         kept_sum_ff   <= '0;
         burst_cmd_ff  <= CMD_CAL;
         burst_chan_ff <= '0;
      end else if (accept) begin
         count_ff      <= (count_in >= target) ? '0 : count_in;
         sum_ff        <= sum_in;
         kept_sum_ff   <= kept_sum_in;
         burst_cmd_ff  <= cmd;
         burst_chan_ff <= chan_index;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kept_ff <= kept_in;
      end
   end

endmodule

// ===== rtl/nfcal_scale.sv =====
// Two-stage averager: magnitude times reciprocal, then shift and restore the sign.
module nfcal_scale #(
   parameter int CAL_SAMPLES    = 16,
   parameter int DROP_HIGHEST   = 4,
   parameter int LISTEN_SAMPLES = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_free,
   input  nfcal_pkg::nfcal_tag_type                in_tag,
   input  logic signed
      [nfcal_pkg::sum_width(CAL_SAMPLES, LISTEN_SAMPLES)-1:0] in_sum,
   output logic                                    load_s2,
   output nfcal_pkg::nfcal_tag_type                s1_tag,
   output logic                                    out_valid,
   input  logic                                    out_free,
   output nfcal_pkg::nfcal_tag_type                out_tag,
   output logic signed [nfcal_pkg::LEVEL_W-1:0]    out_avg
);
   import nfcal_pkg::*;

   localparam int SUM_W      = sum_width(CAL_SAMPLES, LISTEN_SAMPLES);
   localparam int MAG_W      = SUM_W - 1;
   localparam int CAL_DIV    = CAL_SAMPLES - eff_drop(CAL_SAMPLES, DROP_HIGHEST);
   localparam int LISTEN_DIV = LISTEN_SAMPLES;
   localparam int DIV_MAX    = (CAL_DIV > LISTEN_DIV) ? CAL_DIV : LISTEN_DIV;
   // With 2^SHIFT above magnitude times divisor, the rounded-up reciprocal is exact.
   localparam int SHIFT      = MAG_W + $clog2(DIV_MAX);
   localparam int RCP_W      = SHIFT + 1;
   localparam int PROD_W     = MAG_W + RCP_W;
   localparam logic [RCP_W-1:0] CAL_RCP =
      RCP_W'(((longint'(1) << SHIFT) + CAL_DIV - 1) / CAL_DIV);
   localparam logic [RCP_W-1:0] LISTEN_RCP =
      RCP_W'(((longint'(1) << SHIFT) + LISTEN_DIV - 1) / LISTEN_DIV);

   logic                    s1_valid_ff, s2_valid_ff;
   nfcal_tag_type           s1_tag_ff, s2_tag_ff;
   logic signed [SUM_W-1:0] s1_sum_ff, sum_abs;
   logic                    s1_neg, s2_neg_ff;
   logic [MAG_W-1:0]        mag;
   logic [RCP_W-1:0]        rcp;
   logic [PROD_W-1:0]       prod, s2_prod_ff;
   logic [LEVEL_W-1:0]      quot;
   logic                    s2_free;

   assign s2_free = !s2_valid_ff || out_free;
   assign in_free = !s1_valid_ff || s2_free;
   assign load_s2 = s1_valid_ff && s2_free;
   assign s1_tag  = s1_tag_ff;

   assign s1_neg  = s1_sum_ff[SUM_W-1];
   assign sum_abs = s1_neg ? -s1_sum_ff : s1_sum_ff;
   assign mag     = sum_abs[MAG_W-1:0];
   assign rcp     = (s1_tag_ff.kind == CMD_LISTEN) ? LISTEN_RCP : CAL_RCP;
   assign prod    = PROD_W'(mag) * PROD_W'(rcp);

   // Dividing the magnitude and negating afterwards truncates toward zero.
   assign quot      = s2_prod_ff[SHIFT +: LEVEL_W];
   assign out_avg   = s2_neg_ff ? -$signed(quot) : $signed(quot);
   assign out_valid = s2_valid_ff;
   assign out_tag   = s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_free) begin
         s1_tag_ff <= in_tag;
         s1_sum_ff <= in_sum;
      end
      if (load_s2) begin
         s2_tag_ff  <= s1_tag_ff;
         s2_neg_ff  <= s1_neg;
         s2_prod_ff <= prod;
      end
   end

endmodule

// ===== rtl/noise_floor_calibrate_and_listen.sv =====
// Noise-floor calibration and clear-channel check: one signal-strength word is
// taken every cycle while req_stall is low, and the burst state (count, sum,
// largest calibration samples) is updated in the cycle a word is taken. The
// word that completes a burst passes the scaling stages and the output register:
// one stage forms the magnitude times a reciprocal of the sample count, the next
// restores the sign, adds squelch, reads the per-channel noise-floor memory and
// writes it back on a saved calibration. Up to three results can wait behind
// a stalled output before req_stall rises. The floor memory reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
`include "noise_floor_calibrate_and_listen_assert.svh"

module noise_floor_calibrate_and_listen #(
   parameter int CAL_SAMPLES    = 16,
   parameter int DROP_HIGHEST   = 4,
   parameter int LISTEN_SAMPLES = 4,
   parameter int CHANNELS       = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [nfcal_pkg::CHAN_W-1:0]          req_chan_index,
   input  logic signed [nfcal_pkg::RSSI_W-1:0]   req_rssi_dbm,
   input  logic                                  req_save_floor,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_kind,
   output logic [nfcal_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic signed [nfcal_pkg::LEVEL_W-1:0]  rsp_level_dbm,
   output logic                                  rsp_channel_clear,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [nfcal_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [nfcal_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nfcal_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import nfcal_pkg::*;

   localparam int SUM_W  = sum_width(CAL_SAMPLES, LISTEN_SAMPLES);
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                        accept, done, s1_free, load_s2, s2_valid, s2_move, out_free;
   nfcal_tag_type               done_tag, s1_tag, s2_tag;
   logic signed [SUM_W-1:0]     done_sum;
   logic signed [LEVEL_W-1:0]   s2_avg, level, floor_raw, floor_val, ram_rdata;
   logic signed [THRESH_W-1:0]  thresh;
   logic [ADDR_W-1:0]           s2_addr;
   logic                        in_range, clear, ram_we;

   logic signed [SQUELCH_W-1:0] squelch_ff;
   logic [CHANNELS-1:0]         floor_valid_ff;
   logic                        fwd_valid_ff;
   logic [ADDR_W-1:0]           fwd_addr_ff;
   logic signed [LEVEL_W-1:0]   fwd_data_ff;
   logic                        rsp_valid_ff, rsp_kind_ff, rsp_clear_ff;
   logic [CHAN_W-1:0]           rsp_chan_ff;
   logic signed [LEVEL_W-1:0]   rsp_level_ff;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_SQUELCH) ? CSR_DATA_W'(squelch_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         squelch_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_SQUELCH)) begin
         squelch_ff <= csr_pwdata[SQUELCH_W-1:0];
      end
   end

   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;

   nfcal_burst #(
      .CAL_SAMPLES   (CAL_SAMPLES),
      .DROP_HIGHEST  (DROP_HIGHEST),
      .LISTEN_SAMPLES(LISTEN_SAMPLES)
   ) u_burst (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .chan_index(req_chan_index),
      .rssi_dbm  (req_rssi_dbm),
      .save_floor(req_save_floor),
      .done      (done),
      .done_tag  (done_tag),
      .done_sum  (done_sum)
   );

   nfcal_scale #(
      .CAL_SAMPLES   (CAL_SAMPLES),
      .DROP_HIGHEST  (DROP_HIGHEST),
      .LISTEN_SAMPLES(LISTEN_SAMPLES)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (done),
      .in_free  (s1_free),
      .in_tag   (done_tag),
      .in_sum   (done_sum),
      .load_s2  (load_s2),
      .s1_tag   (s1_tag),
      .out_valid(s2_valid),
      .out_free (out_free),
      .out_tag  (s2_tag),
      .out_avg  (s2_avg)
   );

   // The floor is read as the result moves into the last stage and is held there.
   nfcal_ram #(
      .WIDTH(LEVEL_W),
      .DEPTH(CHANNELS)
   ) u_floor_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(s2_addr),
      .wr_data(level),
      .rd_en  (load_s2),
      .rd_addr(ADDR_W'(s1_tag.chan)),
      .rd_data(ram_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid && out_free;
   assign s2_addr  = ADDR_W'(s2_tag.chan);
   assign in_range = int'(s2_tag.chan) < CHANNELS;

   // The last write is forwarded, since it may land in the cycle of the read.
   assign floor_raw = (fwd_valid_ff && (fwd_addr_ff == s2_addr)) ? fwd_data_ff : ram_rdata;
   assign floor_val = (in_range && floor_valid_ff[s2_addr]) ? floor_raw : '0;

   assign level  = (s2_tag.kind == CMD_CAL) ? (s2_avg + LEVEL_W'(squelch_ff)) : s2_avg;
   assign thresh = THRESH_W'(floor_val) + THRESH_W'(squelch_ff);
   assign clear  = (s2_tag.kind == CMD_LISTEN) && (THRESH_W'(s2_avg) < thresh);
   assign ram_we = s2_move && (s2_tag.kind == CMD_CAL) && s2_tag.save && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_valid_ff <= '0;
         fwd_valid_ff   <= 1'b0;
      end else if (ram_we) begin
         floor_valid_ff[s2_addr] <= 1'b1;
         fwd_valid_ff            <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         fwd_addr_ff <= s2_addr;
         fwd_data_ff <= level;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_kind_ff  <= s2_tag.kind;
         rsp_chan_ff  <= s2_tag.chan;
         rsp_level_ff <= level;
         rsp_clear_ff <= clear;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_channel   = rsp_chan_ff;
   assign rsp_level_dbm     = rsp_level_ff;
   assign rsp_channel_clear = rsp_clear_ff;

   `NFCAL_ASSERT_NEXT(a_result_lands, s2_move, rsp_valid_ff, "finished result did not reach the output")
   `NFCAL_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && rsp_stall, !s2_move, "stalled output word overwritten")
   `NFCAL_ASSERT_NOW(a_cal_not_clear, rsp_valid_ff && (rsp_kind_ff == CMD_CAL), !rsp_clear_ff, "calibration result flagged clear")
   `NFCAL_ASSERT_NOW(a_listen_range, rsp_valid_ff && (rsp_kind_ff == CMD_LISTEN), (rsp_level_ff >= -10'sd256) && (rsp_level_ff <= 10'sd255), "listen average outside sample range")

endmodule
